FILE: rtl/frwt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frwt_pkg
// Shared constants and the per-beat control struct of the fractional rank
// block.
// ---------------------------------------------------------------------------
package frwt_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int SAMPLE_W  = 32;

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	typedef struct packed {
		logic                vld;
		logic [1:0]          mode;
		logic                full;
		logic [SAMPLE_W-1:0] sample;
	} ctl_t;

endpackage

FILE: rtl/frwt_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frwt_req_if / frwt_rsp_if
// Valid/ready channels for request beats and result beats.
// ---------------------------------------------------------------------------
interface frwt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic signed [frwt_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output mode, output sample, input ready);
	modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface frwt_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] rank_doubled;
	logic [1:0] status;
	logic [6:0] stored_total;

	modport source (output valid, output rank_doubled, output status, output stored_total,
		input ready);
	modport sink   (input valid, input rank_doubled, input status, input stored_total,
		output ready);
endinterface

FILE: rtl/frwt_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frwt_cell
// One sample slot of the chain: stores the insert aimed at its slot and adds
// its below/equal vote to a passing query, then hands the beat on.
// ---------------------------------------------------------------------------
module frwt_cell #(
	parameter int CW  = $clog2(frwt_pkg::DEPTH_DEF + 1),
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  frwt_pkg::ctl_t       prv_ctl,
	input  logic [CW-1:0]        prv_cnt,
	input  logic [CW-1:0]        prv_total,
	input  logic [CW-1:0]        prv_below,
	input  logic [CW-1:0]        prv_equal,
	output frwt_pkg::ctl_t       ctl_q,
	output logic [CW-1:0]        cnt_q,
	output logic [CW-1:0]        total_q,
	output logic [CW-1:0]        below_q,
	output logic [CW-1:0]        equal_q
);

	logic [frwt_pkg::SAMPLE_W-1:0] sample_q;
	logic                          wr;
	logic                          qry;
	logic                          lt;
	logic                          eq;

	always_comb begin
		wr  = prv_ctl.vld && (prv_ctl.mode == frwt_pkg::MODE_INSERT) && !prv_ctl.full
			&& (prv_cnt == CW'(IDX));
		qry = prv_ctl.vld && (prv_ctl.mode == frwt_pkg::MODE_QUERY) && (prv_cnt > CW'(IDX));
		lt  = $signed(sample_q) < $signed(prv_ctl.sample);
		eq  = sample_q == prv_ctl.sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q    <= '0;
			cnt_q    <= '0;
			total_q  <= '0;
			below_q  <= '0;
			equal_q  <= '0;
			sample_q <= '0;
		end else if (en) begin
			ctl_q   <= prv_ctl;
			cnt_q   <= prv_cnt;
			total_q <= prv_total;
			below_q <= prv_below + CW'(qry && lt);
			equal_q <= prv_equal + CW'(qry && eq);
			if (wr) begin
				sample_q <= prv_ctl.sample;
			end
		end
	end

endmodule

FILE: rtl/fractional_rank_with_ties_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fractional_rank_with_ties_core
// Multiset of up to DEPTH signed samples answering doubled fractional rank
// queries with ties averaged.
// ---------------------------------------------------------------------------
// Every beat (clear, insert, query) runs down a chain of DEPTH cells, one
// cell per sample slot, and its result appears at the end of the chain once
// it has passed the register of every cell. A new beat is taken every cycle
// unless a result waits on rsp.ready, which holds the whole chain, so the
// sustained rate is one beat per cycle. Inserts land in their slot as they
// pass it, so beats always see the store in the order they were sent.
// ---------------------------------------------------------------------------
module fractional_rank_with_ties_core #(
	parameter int DEPTH = frwt_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	frwt_req_if.sink      req,
	frwt_rsp_if.source    rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = (CW + 2 > 9) ? CW + 2 : 9;
	localparam int TW = (CW > 8) ? CW : 8;

	frwt_pkg::ctl_t  ctl   [0:DEPTH];
	logic [CW-1:0]   cnt   [0:DEPTH];
	logic [CW-1:0]   total [0:DEPTH];
	logic [CW-1:0]   below [0:DEPTH];
	logic [CW-1:0]   equal [0:DEPTH];

	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_nxt;
	logic            full;
	logic            en;
	logic            acc;
	logic [RW-1:0]   rank_w;
	logic [TW-1:0]   tot_w;

	assign en        = !(ctl[DEPTH].vld && !rsp.ready);
	assign req.ready = en;
	assign acc       = req.valid && en;
	assign full      = count_q >= CW'(DEPTH);

	always_comb begin
		count_nxt = count_q;
		case (req.mode)
			frwt_pkg::MODE_CLEAR:  count_nxt = '0;
			frwt_pkg::MODE_INSERT: count_nxt = full ? count_q : count_q + CW'(1);
			default:               count_nxt = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (acc) begin
			count_q <= count_nxt;
		end
	end

	assign ctl[0].vld    = req.valid;
	assign ctl[0].mode   = req.mode;
	assign ctl[0].full   = full;
	assign ctl[0].sample = req.sample;
	assign cnt[0]        = count_q;
	assign total[0]      = count_nxt;
	assign below[0]      = '0;
	assign equal[0]      = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		frwt_cell #(
			.CW  (CW),
			.IDX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.prv_ctl   (ctl[i]),
			.prv_cnt   (cnt[i]),
			.prv_total (total[i]),
			.prv_below (below[i]),
			.prv_equal (equal[i]),
			.ctl_q     (ctl[i+1]),
			.cnt_q     (cnt[i+1]),
			.total_q   (total[i+1]),
			.below_q   (below[i+1]),
			.equal_q   (equal[i+1])
		);
	end

	always_comb begin
		rank_w = (RW'(below[DEPTH]) << 1) + RW'(equal[DEPTH]) + RW'(1);
		tot_w  = TW'(total[DEPTH]);

		rsp.valid        = ctl[DEPTH].vld;
		rsp.status       = frwt_pkg::ST_OK;
		rsp.rank_doubled = '0;
		rsp.stored_total = (tot_w > TW'(127)) ? 7'd127 : tot_w[6:0];

		if (ctl[DEPTH].mode == frwt_pkg::MODE_INSERT && ctl[DEPTH].full) begin
			rsp.status = frwt_pkg::ST_FULL;
		end else if (ctl[DEPTH].mode == frwt_pkg::MODE_QUERY) begin
			if (equal[DEPTH] == '0) begin
				rsp.status = frwt_pkg::ST_ABSENT;
			end else begin
				rsp.rank_doubled = (rank_w > RW'(255)) ? 8'd255 : rank_w[7:0];
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("sample count beyond depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.mode == frwt_pkg::MODE_CLEAR |=> count_q == '0)
		else $error("clear did not empty the store");

	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == frwt_pkg::ST_FULL |-> total[DEPTH] == CW'(DEPTH))
		else $error("full status with store not full");

	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl[DEPTH].vld && ctl[DEPTH].mode == frwt_pkg::MODE_QUERY
		|-> (CW+1)'(below[DEPTH]) + (CW+1)'(equal[DEPTH]) <= (CW+1)'(cnt[DEPTH]))
		else $error("rank votes exceed stored samples");

endmodule

FILE: sim/rank_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rank_checker
// Watches the request and result channels of the fractional rank block,
// keeps its own copy of the sample multiset, works out the result of every
// accepted request beat and compares each result beat field by field.
// ---------------------------------------------------------------------------
module rank_checker #(
	parameter int DEPTH = frwt_pkg::DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	frwt_req_if  req,
	frwt_rsp_if  rsp,
	output int   fail_count,
	output int   pending,
	output int   checked,
	output int   full_seen,
	output int   absent_seen,
	output int   tie_seen
);

	typedef struct packed {
		logic [7:0] rank_doubled;
		logic [1:0] status;
		logic [6:0] stored_total;
	} rank_result_t;

	logic signed [frwt_pkg::SAMPLE_W-1:0] held [DEPTH];
	int                                   held_n;
	rank_result_t                         rank_due [$];

	// updates the held multiset and returns the result of one request beat
	function automatic rank_result_t predict_rank(input logic [1:0] mode,
			input logic signed [frwt_pkg::SAMPLE_W-1:0] sample);
		rank_result_t r;
		int below;
		int same;
		int rank2;
		r = '0;
		below = 0;
		same = 0;
		case (mode)
			frwt_pkg::MODE_CLEAR: begin
				held_n = 0;
			end
			frwt_pkg::MODE_INSERT: begin
				if (held_n >= DEPTH) begin
					r.status = frwt_pkg::ST_FULL;
					full_seen++;
				end else begin
					held[held_n] = sample;
					held_n++;
				end
			end
			frwt_pkg::MODE_QUERY: begin
				for (int i = 0; i < held_n; i++) begin
					if (held[i] < sample)
						below++;
					else if (held[i] == sample)
						same++;
				end
				if (same == 0) begin
					r.status = frwt_pkg::ST_ABSENT;
					absent_seen++;
				end else begin
					rank2 = 2 * below + same + 1;
					r.rank_doubled = (rank2 > 255) ? 8'd255 : 8'(rank2);
					if (same > 1)
						tie_seen++;
				end
			end
			default: ;
		endcase
		r.stored_total = (held_n > 127) ? 7'd127 : 7'(held_n);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rank_result_t due;
		rank_result_t got;
		int bad;
		if (!arst_n) begin
			held_n = 0;
			full_seen = 0;
			absent_seen = 0;
			tie_seen = 0;
			rank_due.delete();
			fail_count <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			bad = 0;
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.rank_doubled, rsp.status, rsp.stored_total};
				if (rank_due.size() == 0) begin
					$display("%0t: result beat with none expected: rank_doubled %0d",
						$time, got.rank_doubled);
					$display("%0t:   status %0d stored_total %0d", $time, got.status,
						got.stored_total);
					bad++;
				end else begin
					due = rank_due.pop_front();
					if (got.rank_doubled !== due.rank_doubled) begin
						$display("%0t: rank_doubled expected %0d actual %0d", $time,
							due.rank_doubled, got.rank_doubled);
						bad++;
					end
					if (got.status !== due.status) begin
						$display("%0t: status expected %0d actual %0d", $time, due.status,
							got.status);
						bad++;
					end
					if (got.stored_total !== due.stored_total) begin
						$display("%0t: stored_total expected %0d actual %0d", $time,
							due.stored_total, got.stored_total);
						bad++;
					end
				end
				checked <= checked + 1;
			end
			if (req.valid && req.ready)
				rank_due.push_back(predict_rank(req.mode, req.sample));
			fail_count <= fail_count + bad;
			pending <= rank_due.size();
		end
	end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives the fractional rank block with a short directed sequence and then
// random clear / insert / query sessions built around small value pools so
// that ties, full stores and absent values come up often. Both channels
// idle at random; the result side holds off once for a long stretch so the
// block backs up. The checker module does the predicting and comparing.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int         DEPTH      = frwt_pkg::DEPTH_DEF;
	localparam int         ITEMS      = 1850;
	localparam int         HOLD_AT    = 700;
	localparam int         HOLD_LEN   = 300;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam logic signed [frwt_pkg::SAMPLE_W-1:0] S_MIN = 32'h8000_0000;
	localparam logic signed [frwt_pkg::SAMPLE_W-1:0] S_MAX = 32'h7fff_ffff;
	localparam logic signed [frwt_pkg::SAMPLE_W-1:0] S_NEG = 32'hffff_ffff;

	logic clk = 1'b0;
	logic arst_n;

	frwt_req_if req_ch ();
	frwt_rsp_if rsp_ch ();

	int fail_count;
	int pending;
	int checked;
	int full_seen;
	int absent_seen;
	int tie_seen;

	int  sent = 0;
	int  mode_seen [4] = '{0, 0, 0, 0};
	bit  send_quiet = 1'b0;
	bit  recv_quiet = 1'b0;
	bit  hold_on = 1'b0;

	logic signed [frwt_pkg::SAMPLE_W-1:0] placed [$];
	logic signed [frwt_pkg::SAMPLE_W-1:0] pool [8];

	fractional_rank_with_ties_core #(.DEPTH(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	rank_checker #(.DEPTH(DEPTH)) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked),
		.full_seen   (full_seen),
		.absent_seen (absent_seen),
		.tie_seen    (tie_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic send_beat(input logic [1:0] mode,
			input logic [frwt_pkg::SAMPLE_W-1:0] sample);
		int gap;
		if (sent % 50 == 0)
			send_quiet = ($urandom_range(0, 3) == 0);
		gap = (send_quiet || hold_on) ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= mode;
		req_ch.sample <= sample;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sent++;
		mode_seen[mode]++;
	endtask

	task automatic place_sample(input logic signed [frwt_pkg::SAMPLE_W-1:0] v);
		send_beat(frwt_pkg::MODE_INSERT, v);
		placed.push_back(v);
	endtask

	function automatic logic signed [frwt_pkg::SAMPLE_W-1:0] pick_value();
		if ($urandom_range(0, 7) != 0)
			return pool[$urandom_range(0, 7)];
		case ($urandom_range(0, 3))
			0: return S_MIN;
			1: return S_MAX;
			2: return S_NEG;
			default: return '0;
		endcase
	endfunction

	function automatic logic signed [frwt_pkg::SAMPLE_W-1:0] pick_query();
		logic signed [frwt_pkg::SAMPLE_W-1:0] v;
		if (placed.size() != 0 && $urandom_range(0, 4) != 0) begin
			v = placed[$urandom_range(0, placed.size() - 1)];
			if ($urandom_range(0, 7) == 0)
				v = v + 1;
		end else begin
			v = $urandom;
		end
		return v;
	endfunction

	initial begin : stim
		int fill;
		int asks;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.mode <= frwt_pkg::MODE_CLEAR;
		req_ch.sample <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, extremes, ties, unused mode, clear
		send_beat(frwt_pkg::MODE_CLEAR, S_MAX);
		send_beat(frwt_pkg::MODE_QUERY, 32'sd5);
		place_sample(S_MIN);
		place_sample(S_MAX);
		place_sample('0);
		place_sample(S_NEG);
		place_sample('0);
		send_beat(frwt_pkg::MODE_QUERY, S_MIN);
		send_beat(frwt_pkg::MODE_QUERY, S_MAX);
		send_beat(frwt_pkg::MODE_QUERY, '0);
		send_beat(frwt_pkg::MODE_QUERY, S_NEG);
		send_beat(frwt_pkg::MODE_QUERY, 32'sd1);
		send_beat(MODE_SPARE, S_MIN);
		send_beat(frwt_pkg::MODE_QUERY, '0);
		send_beat(frwt_pkg::MODE_CLEAR, '0);
		placed.delete();
		send_beat(frwt_pkg::MODE_QUERY, '0);
		place_sample(32'sd7);
		place_sample(32'sd7);
		place_sample(32'sd7);
		send_beat(frwt_pkg::MODE_QUERY, 32'sd7);
		send_beat(MODE_SPARE, S_NEG);

		// random sessions
		while (sent < ITEMS) begin
			if ($urandom_range(0, 5) != 0) begin
				send_beat(frwt_pkg::MODE_CLEAR, $urandom);
				placed.delete();
			end
			for (int k = 0; k < 8; k++)
				pool[k] = $urandom_range(0, 1) ? 32'($urandom)
					: 32'($urandom_range(0, 24)) - 32'd12;
			fill = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 16);
			asks = $urandom_range(2, 12);
			while (fill + asks > 0) begin
				if ($urandom_range(0, 29) == 0) begin
					if ($urandom_range(0, 1) == 0) begin
						send_beat(MODE_SPARE, $urandom);
					end else begin
						send_beat(frwt_pkg::MODE_CLEAR, $urandom);
						placed.delete();
					end
				end else if (fill > 0 && (asks == 0 || $urandom_range(0, 2) != 0)) begin
					place_sample(pick_value());
					fill--;
				end else begin
					send_beat(frwt_pkg::MODE_QUERY, pick_query());
					asks--;
				end
			end
		end
		req_ch.valid <= 1'b0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (DEPTH + 16) @(posedge clk);
		$display("Sent %0d beats: %0d inserts, %0d queries, %0d clears, %0d with the unused mode.",
			sent, mode_seen[frwt_pkg::MODE_INSERT], mode_seen[frwt_pkg::MODE_QUERY],
			mode_seen[frwt_pkg::MODE_CLEAR], mode_seen[MODE_SPARE]);
		$display("Checked %0d results: %0d refused inserts, %0d absent queries, %0d tied queries.",
			checked, full_seen, absent_seen, tie_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin : drain
		int stall;
		int got;
		rsp_ch.ready <= 1'b0;
		got = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (got % 50 == 0)
				recv_quiet = ($urandom_range(0, 3) == 0);
			stall = recv_quiet ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			got++;
			if (got == HOLD_AT) begin
				// long hold-off so the chain fills and backs up the request side
				hold_on = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_on = 1'b0;
			end
		end
	end

	initial begin : watchdog
		#800000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
